[design/cwg_pkg.sv]
// Shared types, constants and stage tables for the cosine window generator.
package cwg_pkg;

    localparam int MAX_LENGTH     = 4096;
    localparam int COEF_FRAC_BITS = 15;
    localparam int IDX_W          = 12;
    localparam int LEN_W          = 13;
    localparam int TYPE_W         = 2;
    localparam int COEF_W         = 16;
    localparam int PHASE_BITS     = 20;
    localparam int Q_W            = 30;

    localparam int DIV_CELLS    = PHASE_BITS;
    localparam int SERIES_CELLS = 4;
    // decode, radians, square, three stages per series cell, sine product, sign
    localparam int LANE_LAT     = 3 + 3 * SERIES_CELLS + 2;
    localparam int TOTAL_LAT    = 1 + DIV_CELLS + LANE_LAT + 3;

    localparam logic [LEN_W-1:0] RESET_LENGTH = 13'd128;

    localparam logic [17:0] EIGHTH  = 18'h20000;
    localparam logic [18:0] QUARTER = 19'h40000;
    localparam logic [32:0] ANGLE_SCALE = 33'd6746518852;
    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

    localparam logic [29:0] C_HALF = 30'd536870912;
    localparam logic [29:0] C_054  = 30'd579820585;
    localparam logic [29:0] C_046  = 30'd493921239;
    localparam logic [29:0] C_042  = 30'd450971566;
    localparam logic [29:0] C_008  = 30'd85899346;

    localparam int ROUND_SHIFT = 60 - COEF_FRAC_BITS;

    typedef enum logic [TYPE_W-1:0] {
        WIN_HANN     = 2'd0,
        WIN_HAMMING  = 2'd1,
        WIN_BLACKMAN = 2'd2
    } t_window;

    typedef enum logic {
        REG_TYPE   = 1'b0,
        REG_LENGTH = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic              valid;
        logic              last;
        logic              err;
        logic [TYPE_W-1:0] wtype;
    } t_side;

    typedef struct packed {
        logic [29:0] a;
        logic [29:0] a2;
        logic [30:0] h;
        logic        sin_ser;
        logic        neg;
    } t_lane_bus;

    typedef struct packed {
        logic [6:0]  div_cos;
        logic [6:0]  div_sin;
        logic [31:0] recip_cos;
        logic [31:0] recip_sin;
    } t_series_k;

    localparam t_series_k SERIES_K [SERIES_CELLS] = '{
        '{7'd56, 7'd72, 32'((64'd1 << 32) / 56), 32'((64'd1 << 32) / 72)},
        '{7'd30, 7'd42, 32'((64'd1 << 32) / 30), 32'((64'd1 << 32) / 42)},
        '{7'd12, 7'd20, 32'((64'd1 << 32) / 12), 32'((64'd1 << 32) / 20)},
        '{7'd2,  7'd6,  32'((64'd1 << 32) / 2),  32'((64'd1 << 32) / 6)}
    };

endpackage

[design/cosine_window_generator_top.sv]
// Top level: configuration, phase divider chain, two cosine lanes, window sum.
//
// Takes one sample index per clock (start with busy low) and returns its Hann,
// Hamming or Blackman coefficient as unsigned Q1.15, marked by a one-cycle
// o_valid. The path is the input register, the 20-cell restoring divider that
// forms the phase (one phase bit per cell), the 17-stage cosine lane (four
// series cells of three stages) and three stages of weighting, sum and
// rounding. Items stream back to back; busy is high only while in reset, and
// results cannot be held off, so take them when o_valid is high. Write
// window_type and window_length only while no item is in flight.
module cosine_window_generator_top
    import cwg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic [IDX_W-1:0]  i_sample_index,
    input  logic              i_cfg_we,
    input  logic [0:0]        i_cfg_index,
    input  logic [LEN_W-1:0]  i_cfg_data,
    output logic              busy,
    output logic              o_valid,
    output logic [COEF_W-1:0] o_coefficient,
    output logic              o_last_coefficient,
    output logic              o_index_error
);

    logic [TYPE_W-1:0] r_window_type;
    logic [LEN_W-1:0]  r_window_length;
    logic              r_busy;

    logic              w_accept;
    logic [LEN_W-1:0]  w_len;

    logic [LEN_W-1:0]  r0_num;
    logic [LEN_W-1:0]  r0_den;
    t_side             r0_side;

    logic [LEN_W-1:0]  w_rem  [DIV_CELLS+1];
    logic [LEN_W-1:0]  w_den  [DIV_CELLS+1];
    logic [19:0]       w_quo  [DIV_CELLS+1];
    t_side             w_side [DIV_CELLS+1];

    logic signed [31:0] w_c1;
    logic signed [31:0] w_c2;
    t_side              r_side_dly [LANE_LAT];

    logic [29:0]        w_k1;
    logic [29:0]        w_k2;
    logic [29:0]        w_k0;
    logic signed [62:0] w_m1;
    logic signed [62:0] w_m2;
    logic signed [62:0] r_m1;
    logic signed [62:0] r_m2;
    logic [59:0]        r_base;
    t_side              r_side_w1;
    logic signed [63:0] r_sum;
    t_side              r_side_w2;
    logic [60:0]        w_w;
    logic [61:0]        w_rnd;
    logic [61:0]        w_full;
    logic [COEF_W-1:0]  w_sat;

    logic              r_valid;
    logic [COEF_W-1:0] r_coef;
    logic              r_last;
    logic              r_err;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_type   <= WIN_HANN;
            r_window_length <= RESET_LENGTH;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_TYPE:   r_window_type   <= i_cfg_data[TYPE_W-1:0];
                REG_LENGTH: r_window_length <= i_cfg_data;
                default:    r_window_length <= r_window_length;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy     = r_busy;
    assign w_accept = start && !r_busy;
    assign w_len    = (r_window_length > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH)
                                                             : r_window_length;

    // input beat: numerator k+1 and divisor N+1
    always_ff @(posedge i_clk) begin
        r0_num <= LEN_W'(i_sample_index) + 1'b1;
        r0_den <= w_len + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_side <= '0;
        end else begin
            r0_side.valid <= w_accept;
            r0_side.last  <= LEN_W'(i_sample_index) == (w_len - 1'b1);
            r0_side.err   <= LEN_W'(i_sample_index) >= w_len;
            r0_side.wtype <= r_window_type;
        end
    end

    assign w_rem[0]  = r0_num;
    assign w_den[0]  = r0_den;
    assign w_quo[0]  = '0;
    assign w_side[0] = r0_side;

    for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
        cwg_div_cell u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_rem   (w_rem[g]),
            .i_den   (w_den[g]),
            .i_quo   (w_quo[g]),
            .i_side  (w_side[g]),
            .o_rem   (w_rem[g+1]),
            .o_den   (w_den[g+1]),
            .o_quo   (w_quo[g+1]),
            .o_side  (w_side[g+1])
        );
    end

    cwg_cos_lane u_lane1 (
        .i_clk   (i_clk),
        .i_phase (w_quo[DIV_CELLS]),
        .o_cos   (w_c1)
    );

    cwg_cos_lane u_lane2 (
        .i_clk   (i_clk),
        .i_phase ({w_quo[DIV_CELLS][PHASE_BITS-2:0], 1'b0}),
        .o_cos   (w_c2)
    );

    // hold flags alongside the cosine lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LANE_LAT; i++) begin
                r_side_dly[i] <= '0;
            end
        end else begin
            r_side_dly[0] <= w_side[DIV_CELLS];
            for (int i = 1; i < LANE_LAT; i++) begin
                r_side_dly[i] <= r_side_dly[i-1];
            end
        end
    end

    always_comb begin
        case (t_window'(r_side_dly[LANE_LAT-1].wtype))
            WIN_HAMMING: begin
                w_k0 = C_054;
                w_k1 = C_046;
                w_k2 = '0;
            end
            WIN_BLACKMAN: begin
                w_k0 = C_042;
                w_k1 = C_HALF;
                w_k2 = C_008;
            end
            default: begin
                w_k0 = C_HALF;
                w_k1 = C_HALF;
                w_k2 = '0;
            end
        endcase
    end

    assign w_m1 = 63'($signed({1'b0, w_k1})) * 63'(w_c1);
    assign w_m2 = 63'($signed({1'b0, w_k2})) * 63'(w_c2);

    always_ff @(posedge i_clk) begin
        r_m1   <= w_m1;
        r_m2   <= w_m2;
        r_base <= {w_k0, 30'd0};
        r_sum  <= $signed({4'd0, r_base}) - 64'(r_m1) + 64'(r_m2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_w1 <= '0;
            r_side_w2 <= '0;
        end else begin
            r_side_w1 <= r_side_dly[LANE_LAT-1];
            r_side_w2 <= r_side_w1;
        end
    end

    // clamp to [0, 1.0] in Q60, round half up
    always_comb begin
        if (r_sum < 0) begin
            w_w = '0;
        end else if (r_sum > 64'sd1152921504606846976) begin
            w_w = 61'd1 << 60;
        end else begin
            w_w = r_sum[60:0];
        end
    end

    assign w_rnd  = 62'(w_w) + (62'd1 << (ROUND_SHIFT - 1));
    assign w_full = w_rnd >> ROUND_SHIFT;
    assign w_sat  = (w_full > 62'({COEF_W{1'b1}})) ? {COEF_W{1'b1}} : w_full[COEF_W-1:0];

    always_ff @(posedge i_clk) begin
        r_coef <= r_side_w2.err ? '0 : w_sat;
        r_last <= r_side_w2.last && !r_side_w2.err;
        r_err  <= r_side_w2.err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_side_w2.valid;
        end
    end

    assign o_valid            = r_valid;
    assign o_coefficient      = r_coef;
    assign o_last_coefficient = r_last;
    assign o_index_error      = r_err;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_index_error |-> o_coefficient == '0 && !o_last_coefficient)
        else $error("index error beat carries a coefficient or last mark");

    a_coef_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_coefficient <= COEF_W'(1 << COEF_FRAC_BITS))
        else $error("coefficient above 1.0");

    a_lane_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_side_dly[LANE_LAT-1].valid |->
            (w_c1 <= 32'sd1073741824) && (w_c1 >= -32'sd1073741824))
        else $error("cosine lane out of range");

    a_valid_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_side_w2.valid |=> o_valid)
        else $error("result beat dropped at output stage");

endmodule

[design/cwg_div_cell.sv]
// One restoring-division cell: resolves one phase bit per cycle.
module cwg_div_cell
    import cwg_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [LEN_W-1:0] i_rem,
    input  logic [LEN_W-1:0] i_den,
    input  logic [19:0]      i_quo,
    input  t_side            i_side,
    output logic [LEN_W-1:0] o_rem,
    output logic [LEN_W-1:0] o_den,
    output logic [19:0]      o_quo,
    output t_side            o_side
);

    logic [LEN_W:0]   w_shift;
    logic [LEN_W:0]   w_diff;
    logic             w_ge;
    logic [LEN_W-1:0] r_rem;
    logic [LEN_W-1:0] r_den;
    logic [19:0]      r_quo;
    t_side            r_side;

    assign w_shift = {i_rem, 1'b0};
    assign w_ge    = w_shift >= {1'b0, i_den};
    assign w_diff  = w_shift - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        r_rem <= w_ge ? w_diff[LEN_W-1:0] : w_shift[LEN_W-1:0];
        r_den <= i_den;
        r_quo <= {i_quo[18:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else begin
            r_side <= i_side;
        end
    end

    assign o_rem  = r_rem;
    assign o_den  = r_den;
    assign o_quo  = r_quo;
    assign o_side = r_side;

endmodule

[design/cwg_series_cell.sv]
// One nested-series step: h <= 1 - ((a2*h) >> 30) / d over three stages.
module cwg_series_cell
    import cwg_pkg::*;
(
    input  logic      i_clk,
    input  t_series_k i_k,
    input  t_lane_bus i_bus,
    output t_lane_bus o_bus
);

    logic [60:0] w_p1;
    logic [31:0] w_recip;
    logic [61:0] w_p2;
    logic [6:0]  w_div;
    logic [36:0] w_qc;
    logic [36:0] w_rem;
    logic        w_up;
    logic [30:0] w_q;

    t_lane_bus   r1_bus;
    logic [29:0] r1_prod;
    t_lane_bus   r2_bus;
    logic [29:0] r2_prod;
    logic [29:0] r2_q0;
    t_lane_bus   r3_bus;

    assign w_p1 = 61'(i_bus.a2) * 61'(i_bus.h);

    // quotient estimate by reciprocal, low by at most one
    assign w_recip = r1_bus.sin_ser ? i_k.recip_sin : i_k.recip_cos;
    assign w_p2    = 62'(r1_prod) * 62'(w_recip);

    assign w_div = r2_bus.sin_ser ? i_k.div_sin : i_k.div_cos;
    assign w_qc  = 37'(r2_q0) * 37'(w_div);
    assign w_rem = 37'(r2_prod) - w_qc;
    assign w_up  = w_rem >= 37'(w_div);
    assign w_q   = 31'(r2_q0) + 31'(w_up);

    always_ff @(posedge i_clk) begin
        r1_bus  <= i_bus;
        r1_prod <= w_p1[59:30];
        r2_bus  <= r1_bus;
        r2_prod <= r1_prod;
        r2_q0   <= w_p2[61:32];
        r3_bus.a       <= r2_bus.a;
        r3_bus.a2      <= r2_bus.a2;
        r3_bus.h       <= ONE_Q30 - w_q;
        r3_bus.sin_ser <= r2_bus.sin_ser;
        r3_bus.neg     <= r2_bus.neg;
    end

    assign o_bus = r3_bus;

endmodule

[design/cwg_cos_lane.sv]
// Cosine of a phase in 2^-20 turns: octant fold, angle, series cells, sign.
module cwg_cos_lane
    import cwg_pkg::*;
(
    input  logic                 i_clk,
    input  logic [PHASE_BITS-1:0] i_phase,
    output logic signed [31:0]   o_cos
);

    logic [17:0] w_r;
    logic        w_hi;
    logic [18:0] w_fold;
    logic [50:0] w_ang;
    logic [59:0] w_sq;
    logic [60:0] w_sp;
    t_lane_bus   w_chain [SERIES_CELLS+1];

    logic [17:0]        r1_t;
    logic               r1_sin;
    logic               r1_neg;
    logic [29:0]        r2_a;
    logic               r2_sin;
    logic               r2_neg;
    t_lane_bus          r3_bus;
    logic [30:0]        r4_v;
    logic               r4_neg;
    logic signed [31:0] r5_cos;

    assign w_r    = i_phase[17:0];
    assign w_hi   = w_r > EIGHTH;
    assign w_fold = QUARTER - {1'b0, w_r};
    assign w_ang  = 51'(r1_t) * 51'(ANGLE_SCALE) + 51'(1 << 19);
    assign w_sq   = 60'(r2_a) * 60'(r2_a) + 60'(1 << 29);

    always_ff @(posedge i_clk) begin
        r1_t   <= w_hi ? w_fold[17:0] : w_r;
        // odd quadrants want sine; past the octant the other series applies
        r1_sin <= i_phase[18] ^ w_hi;
        r1_neg <= i_phase[19] ^ i_phase[18];
        r2_a   <= w_ang[49:20];
        r2_sin <= r1_sin;
        r2_neg <= r1_neg;
        r3_bus.a       <= r2_a;
        r3_bus.a2      <= w_sq[59:30];
        r3_bus.h       <= ONE_Q30;
        r3_bus.sin_ser <= r2_sin;
        r3_bus.neg     <= r2_neg;
    end

    assign w_chain[0] = r3_bus;

    for (genvar g = 0; g < SERIES_CELLS; g++) begin : g_cell
        cwg_series_cell u_cell (
            .i_clk (i_clk),
            .i_k   (SERIES_K[g]),
            .i_bus (w_chain[g]),
            .o_bus (w_chain[g+1])
        );
    end

    assign w_sp = 61'(w_chain[SERIES_CELLS].a) * 61'(w_chain[SERIES_CELLS].h);

    always_ff @(posedge i_clk) begin
        r4_v   <= w_chain[SERIES_CELLS].sin_ser ? w_sp[60:30] : w_chain[SERIES_CELLS].h;
        r4_neg <= w_chain[SERIES_CELLS].neg;
        r5_cos <= r4_neg ? -$signed({1'b0, r4_v}) : $signed({1'b0, r4_v});
    end

    assign o_cos = r5_cos;

endmodule
